// ===== rtl/napt_translation_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// napt assertion macros
// shared property wrappers for the translation engine checks
// ----------------------------------------------------------------------------
`ifndef NAPT_TRANSLATION_ENGINE_CORE_DEFINES_SVH
`define NAPT_TRANSLATION_ENGINE_CORE_DEFINES_SVH

// implication checked every edge outside reset
`define NAPT_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication outside reset
`define NAPT_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/napt_pkg.sv =====
// ----------------------------------------------------------------------------
// napt package
// shared types, codes and constants of the translation engine
// ----------------------------------------------------------------------------
package napt_pkg;

  localparam int unsigned MaxLanClientsDef = 8;
  localparam int unsigned MappingDepthDef  = 64;

  localparam logic [31:0] RouterWanReset  = 32'd0;
  localparam logic [31:0] WanPeerReset    = 32'd167772170;
  localparam logic [15:0] FirstDynReset   = 16'd49152;

  typedef enum logic [1:0] {
    CFG_ROUTER_WAN = 2'd0,
    CFG_WAN_PEER   = 2'd1,
    CFG_FIRST_DYN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_LOAD_CLIENT = 2'd0,
    KIND_LOAD_MAP    = 2'd1,
    KIND_PACKET      = 2'd2,
    KIND_NONE        = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_DROP     = 3'd0,
    ACT_LAN_FWD  = 3'd1,
    ACT_OUTBOUND = 3'd2,
    ACT_INBOUND  = 3'd3,
    ACT_FULL     = 3'd4,
    ACT_LOADED   = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIENT_SCAN,
    ST_MAP_SCAN,
    ST_INS_SCAN,
    ST_INS_WRITE,
    ST_DONE
  } state_t;

  // scan modes of the datapath
  typedef enum logic [1:0] {
    SCAN_BY_LAN,
    SCAN_BY_WAN,
    SCAN_INSERT
  } scan_t;

  typedef struct packed {
    logic    load;        // capture input word
    logic    client_add;  // append lan client
    logic    clr_client;  // reset client scan index
    logic    client_step; // examine one client
    logic    clr_map;     // reset table scan index
    logic    map_step;    // examine one table entry
    scan_t   scan;        // what the table scan looks for
    logic    ins_write;   // write the chosen slot
    logic    dyn_inc;     // advance dynamic port
    logic    emit;        // drive result
    action_t act;
  } napt_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  client_full;
    logic  client_done;
    logic  src_lan;
    logic  dst_lan;
    logic  dst_is_peer;
    logic  inbound;
    logic  map_done;
    logic  found;
    logic  slot_found;
    logic  dyn_ok;
  } napt_stat_t;

endpackage

// ===== rtl/napt_ctrl.sv =====
// ----------------------------------------------------------------------------
// napt controller
// sequences client scan, table scans and insertion for each word
// ----------------------------------------------------------------------------
module napt_ctrl
  import napt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  napt_stat_t st,
  output napt_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   outb_r, outb_nxt;   // insert is for a dynamic mapping
  logic   seen_r, seen_nxt;   // table lookup already done before insert

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      outb_r  <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outb_r  <= outb_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    outb_nxt  = outb_r;
    seen_nxt  = seen_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DONE;
          outb_nxt  = 1'b0;
          seen_nxt  = 1'b0;
        end
      end
      ST_DONE: begin
        case (st.kind)
          KIND_LOAD_MAP: state_nxt = ST_INS_SCAN;
          KIND_PACKET:   state_nxt = ST_CLIENT_SCAN;
          default:       state_nxt = ST_IDLE;
        endcase
        if (seen_r) state_nxt = ST_IDLE;
      end
      ST_CLIENT_SCAN: begin
        if (st.client_done) begin
          if ((st.src_lan && !st.dst_lan && st.dst_is_peer) ||
              (!(st.src_lan && st.dst_lan) && !(st.src_lan && st.dst_is_peer) &&
               st.inbound)) begin
            state_nxt = ST_MAP_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MAP_SCAN: begin
        if (st.map_done) begin
          if (st.src_lan && st.dst_is_peer && !st.dst_lan && !st.found &&
              st.dyn_ok && !outb_r) begin
            state_nxt = ST_INS_SCAN;
            outb_nxt  = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_INS_SCAN: begin
        if (st.map_done) begin
          state_nxt = st.slot_found ? ST_INS_WRITE : ST_IDLE;
        end
      end
      ST_INS_WRITE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.scan = SCAN_BY_LAN;
    cmd.act  = ACT_DROP;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.load       = start;
        cmd.clr_client = start;
        cmd.clr_map    = start;
      end
      ST_DONE: begin
        case (st.kind)
          KIND_LOAD_CLIENT: begin
            cmd.emit       = 1'b1;
            cmd.act        = st.client_full ? ACT_FULL : ACT_LOADED;
            cmd.client_add = !st.client_full;
          end
          KIND_NONE: begin
            cmd.emit = 1'b1;
            cmd.act  = ACT_DROP;
          end
          default: ;
        endcase
      end
      ST_CLIENT_SCAN: begin
        cmd.client_step = 1'b1;
        if (st.client_done) begin
          if (st.src_lan && st.dst_lan) begin
            cmd.emit = 1'b1;
            cmd.act  = ACT_LAN_FWD;
          end else if (!(st.src_lan && st.dst_is_peer) && !st.inbound) begin
            cmd.emit = 1'b1;
            cmd.act  = ACT_DROP;
          end
        end
      end
      ST_MAP_SCAN: begin
        cmd.map_step = 1'b1;
        cmd.scan     = (st.src_lan && st.dst_is_peer) ? SCAN_BY_LAN : SCAN_BY_WAN;
        if (st.map_done) begin
          if (st.src_lan && st.dst_is_peer) begin
            if (st.found) begin
              cmd.emit = 1'b1;
              cmd.act  = ACT_OUTBOUND;
            end else if (!st.dyn_ok || outb_r) begin
              cmd.emit = 1'b1;
              cmd.act  = ACT_FULL;
            end else begin
              cmd.clr_map = 1'b1;
            end
          end else begin
            cmd.emit = 1'b1;
            cmd.act  = st.found ? ACT_INBOUND : ACT_DROP;
          end
        end
      end
      ST_INS_SCAN: begin
        cmd.map_step = 1'b1;
        cmd.scan     = SCAN_INSERT;
        if (st.map_done && !st.slot_found) begin
          cmd.emit = 1'b1;
          cmd.act  = ACT_FULL;
        end
      end
      ST_INS_WRITE: begin
        cmd.ins_write = 1'b1;
        cmd.dyn_inc   = outb_r;
        cmd.emit      = 1'b1;
        cmd.act       = outb_r ? ACT_OUTBOUND : ACT_LOADED;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/napt_dp.sv =====
// ----------------------------------------------------------------------------
// napt datapath
// client list, mapping table, dynamic port counter and result register
// ----------------------------------------------------------------------------
module napt_dp
  import napt_pkg::*;
#(
  parameter int unsigned MAX_LAN_CLIENTS = MaxLanClientsDef,
  parameter int unsigned MAPPING_DEPTH   = MappingDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  napt_cmd_t   cmd,
  output napt_stat_t  st,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dest_port,
  input  logic [15:0] in_mapped_wan_port,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [31:0] out_new_source_address,
  output logic [15:0] out_new_source_port,
  output logic [31:0] out_new_dest_address,
  output logic [15:0] out_new_dest_port
);

  localparam int unsigned CW = $clog2(MAX_LAN_CLIENTS + 1);
  localparam int unsigned CI = (MAX_LAN_CLIENTS > 1) ? $clog2(MAX_LAN_CLIENTS) : 1;
  localparam int unsigned MW = $clog2(MAPPING_DEPTH + 1);
  localparam int unsigned MI = $clog2(MAPPING_DEPTH);

  // configuration
  logic [31:0] router_wan_r, wan_peer_r;
  logic [16:0] dyn_port_r;

  // captured word
  kind_t       kind_r;
  logic [31:0] sa_r, da_r;
  logic [15:0] sp_r, dp_r, wp_r;

  logic [31:0] client_mem [MAX_LAN_CLIENTS];
  logic [CW-1:0] client_cnt_r;
  logic [CW-1:0] cidx_r;
  logic          src_lan_r, dst_lan_r;

  logic [63:0]   map_mem [MAPPING_DEPTH];
  logic [MAPPING_DEPTH-1:0] map_valid_r;
  logic [MW-1:0] midx_r;
  logic [MI-1:0] hit_idx_r;
  logic          found_r, slot_r;
  logic [63:0]   hit_ent_r;
  logic [MAPPING_DEPTH-1:0] kill_r;

  logic [31:0] cdata_r;
  logic [63:0] mdata_r;
  logic        cpend_r, mpend_r;   // registered read in flight
  logic [MW-1:0] mrd_r;            // index of mdata_r

  logic [15:0] ins_wport;
  assign ins_wport = (kind_r == KIND_PACKET) ? dyn_port_r[15:0] : wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      router_wan_r <= RouterWanReset;
      wan_peer_r   <= WanPeerReset;
      dyn_port_r   <= {1'b0, FirstDynReset};
    end else begin
      if (cmd.dyn_inc) dyn_port_r <= dyn_port_r + 17'd1;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROUTER_WAN: router_wan_r <= cfg_wdata;
          CFG_WAN_PEER:   wan_peer_r   <= cfg_wdata;
          CFG_FIRST_DYN:  dyn_port_r   <= {1'b0, cfg_wdata[15:0]};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind_t'(in_kind);
      sa_r   <= in_source_address;
      da_r   <= in_dest_address;
      sp_r   <= in_source_port;
      dp_r   <= in_dest_port;
      wp_r   <= in_mapped_wan_port;
    end
  end

  // client list
  always_ff @(posedge clk) begin
    if (cmd.client_add) client_mem[client_cnt_r[CI-1:0]] <= sa_r;
    cdata_r <= client_mem[cidx_r[CI-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_cnt_r <= '0;
      cidx_r       <= '0;
      cpend_r      <= 1'b0;
      src_lan_r    <= 1'b0;
      dst_lan_r    <= 1'b0;
    end else begin
      if (cmd.client_add) client_cnt_r <= client_cnt_r + 1'b1;
      if (cmd.clr_client) begin
        cidx_r    <= '0;
        cpend_r   <= 1'b0;
        src_lan_r <= 1'b0;
        dst_lan_r <= 1'b0;
      end else if (cmd.client_step) begin
        if (cidx_r < client_cnt_r) cidx_r <= cidx_r + 1'b1;
        cpend_r <= (cidx_r < client_cnt_r);
        if (cpend_r && cdata_r == sa_r) src_lan_r <= 1'b1;
        if (cpend_r && cdata_r == da_r) dst_lan_r <= 1'b1;
      end
    end
  end

  // mapping table: word is {lan address, lan port, wan port}
  logic m_lan_hit, m_wan_hit, m_val, m_coll;
  always_comb begin
    m_val     = mpend_r && map_valid_r[mrd_r[MI-1:0]];
    m_lan_hit = (mdata_r[63:32] == sa_r) && (mdata_r[31:16] == sp_r);
    m_wan_hit = (mdata_r[15:0] == ((cmd.scan == SCAN_BY_WAN) ? dp_r : ins_wport));
    m_coll    = m_val && (m_lan_hit || m_wan_hit);
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write) map_mem[hit_idx_r] <= {sa_r, sp_r, ins_wport};
    mdata_r <= map_mem[midx_r[MI-1:0]];
  end

  logic map_end;
  assign map_end = (midx_r == MW'(MAPPING_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
      midx_r      <= '0;
      mrd_r       <= '0;
      mpend_r     <= 1'b0;
      found_r     <= 1'b0;
      slot_r      <= 1'b0;
      kill_r      <= '0;
      hit_idx_r   <= '0;
    end else begin
      if (cmd.clr_map) begin
        midx_r  <= '0;
        mpend_r <= 1'b0;
        found_r <= 1'b0;
        slot_r  <= 1'b0;
        kill_r  <= '0;
      end else if (cmd.map_step) begin
        if (!map_end) midx_r <= midx_r + 1'b1;
        mpend_r <= !map_end;
        mrd_r   <= midx_r;
        if (mpend_r) begin
          case (cmd.scan)
            SCAN_BY_LAN: if (m_val && m_lan_hit && !found_r) begin
              found_r   <= 1'b1;
              hit_ent_r <= mdata_r;
            end
            SCAN_BY_WAN: if (m_val && m_wan_hit && !found_r) begin
              found_r   <= 1'b1;
              hit_ent_r <= mdata_r;
            end
            SCAN_INSERT: begin
              if ((!m_val || m_coll) && !slot_r) begin
                slot_r    <= 1'b1;
                hit_idx_r <= mrd_r[MI-1:0];
              end
              if (m_coll) kill_r[mrd_r[MI-1:0]] <= 1'b1;
            end
            default: ;
          endcase
        end
      end else if (cmd.ins_write) begin
        map_valid_r <= (map_valid_r & ~kill_r) |
                       (MAPPING_DEPTH'(1) << hit_idx_r);
      end
    end
  end

  always_comb begin
    st             = '0;
    st.kind        = kind_r;
    st.client_full = (client_cnt_r >= CW'(MAX_LAN_CLIENTS));
    st.client_done = !cpend_r && (cidx_r >= client_cnt_r) && !cmd.clr_client;
    st.src_lan     = src_lan_r;
    st.dst_lan     = dst_lan_r;
    st.dst_is_peer = (da_r == wan_peer_r);
    st.inbound     = (sa_r == wan_peer_r) && (da_r == router_wan_r);
    st.map_done    = map_end && !mpend_r;
    st.found       = found_r;
    st.slot_found  = slot_r;
    st.dyn_ok      = !dyn_port_r[16];
  end

  // result register; outbound after insert uses the inserted entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_action             <= cmd.act;
      out_new_source_address <= '0;
      out_new_source_port    <= '0;
      out_new_dest_address   <= '0;
      out_new_dest_port      <= '0;
      case (cmd.act)
        ACT_LAN_FWD: begin
          out_new_source_address <= sa_r;
          out_new_source_port    <= sp_r;
          out_new_dest_address   <= da_r;
          out_new_dest_port      <= dp_r;
        end
        ACT_OUTBOUND: begin
          out_new_source_address <= router_wan_r;
          out_new_source_port    <= cmd.ins_write ? ins_wport : hit_ent_r[15:0];
          out_new_dest_address   <= da_r;
          out_new_dest_port      <= dp_r;
        end
        ACT_INBOUND: begin
          out_new_source_address <= sa_r;
          out_new_source_port    <= sp_r;
          out_new_dest_address   <= hit_ent_r[63:32];
          out_new_dest_port      <= hit_ent_r[31:16];
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/napt_translation_engine_core.sv =====
// ----------------------------------------------------------------------------
// napt translation engine core
// address and port translation with lan client list and mapping table
// ----------------------------------------------------------------------------
// One word is taken at a time while busy is low. A client load finishes in the
// done state; a packet scans the client list one entry per cycle, then
// the mapping table one entry per cycle through its registered read port, and
// a new dynamic mapping takes a second table pass plus a write. Each result
// shows on out_valid for one cycle and cannot be held off by the receiver.
module napt_translation_engine_core
  import napt_pkg::*;
#(
  parameter int unsigned MAX_LAN_CLIENTS = MaxLanClientsDef,
  parameter int unsigned MAPPING_DEPTH   = MappingDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dest_port,
  input  logic [15:0] in_mapped_wan_port,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [31:0] out_new_source_address,
  output logic [15:0] out_new_source_port,
  output logic [31:0] out_new_dest_address,
  output logic [15:0] out_new_dest_port
);

`include "napt_translation_engine_core_defines.svh"

  napt_cmd_t  cmd;
  napt_stat_t st;

  napt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  napt_dp #(
    .MAX_LAN_CLIENTS (MAX_LAN_CLIENTS),
    .MAPPING_DEPTH   (MAPPING_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .st                     (st),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_kind                (in_kind),
    .in_source_address      (in_source_address),
    .in_dest_address        (in_dest_address),
    .in_source_port         (in_source_port),
    .in_dest_port           (in_dest_port),
    .in_mapped_wan_port     (in_mapped_wan_port),
    .out_valid              (out_valid),
    .out_action             (out_action),
    .out_new_source_address (out_new_source_address),
    .out_new_source_port    (out_new_source_port),
    .out_new_dest_address   (out_new_dest_address),
    .out_new_dest_port      (out_new_dest_port)
  );

  `NAPT_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "word not taken")
  `NAPT_ASSERT_NXT(a_emit_idle, clk, rst_n, cmd.emit, !busy, "result before word end")
  `NAPT_ASSERT_IMP(a_one_result, clk, rst_n, out_valid, !$past(out_valid), "double result")

endmodule
